### rtl/altp_pkg.sv
package altp_pkg;

    localparam int MAX_POINTS_DEF = 64;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_LENGTH = 2'd2,
        OP_NORM   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [31:0] query_value;
    } in_item_t;

    typedef struct packed {
        logic [16:0] u_value;
        logic [31:0] total_length;
        logic [6:0]  point_count;
        logic        point_dropped;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_STORE,
        ST_SCALE0,
        ST_SCALE1,
        ST_CLAMP,
        ST_SRCH,
        ST_SRCHW,
        ST_RDA,
        ST_RDAW,
        ST_DEN0,
        ST_DEN1,
        ST_NUM,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    // command from controller to datapath
    typedef struct packed {
        logic load;
        logic start_curve;
        logic sq_step;
        logic sqrt_init;
        logic sqrt_step;
        logic store;
        logic scale_step;
        logic clamp;
        logic srch_rd;
        logic srch_eval;
        logic rda;
        logic rda_eval;
        logic den_step;
        logic num_calc;
        logic div_init;
        logic div_step;
        logic fin;
        logic drop;
        logic zero_u;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic empty;
        logic full;
        logic sq_done;
        logic sq_ovf;
        logic sqrt_done;
        logic srch_done;
        logic idx_zero;
        logic idx_end;
        logic div_done;
    } stat_t;

endpackage

### rtl/altp_ctrl.sv
module altp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  altp_pkg::stat_t st,
    output altp_pkg::cmd_t  cmd
);
    import altp_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        in_ready = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                if (st.op == OP_START || (st.op == OP_APPEND && st.empty)) begin
                    cmd.start_curve = 1'b1;
                    state_next = ST_OUT;
                end else if (st.op == OP_APPEND) begin
                    if (st.full) begin
                        cmd.drop = 1'b1;
                        state_next = ST_OUT;
                    end else if (st.sq_done) begin
                        cmd.sqrt_init = 1'b1;
                        state_next = ST_SQRT;
                    end else begin
                        cmd.sq_step = 1'b1;
                    end
                end else if (st.op == OP_NORM) begin
                    state_next = ST_SCALE0;
                end else begin
                    state_next = ST_CLAMP;
                end
            end
            ST_SQRT: begin
                if (st.sqrt_done) state_next = ST_STORE;
                else cmd.sqrt_step = 1'b1;
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                state_next = ST_OUT;
            end
            ST_SCALE0: begin
                cmd.scale_step = 1'b1;
                state_next = ST_SCALE1;
            end
            ST_SCALE1: begin
                cmd.scale_step = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                if (st.empty) begin
                    cmd.zero_u = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    cmd.clamp = 1'b1;
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH: begin
                cmd.srch_rd = 1'b1;
                state_next = ST_SRCHW;
            end
            ST_SRCHW: begin
                cmd.srch_eval = 1'b1;
                if (st.srch_done) state_next = ST_RDA;
                else state_next = ST_SRCH;
            end
            ST_RDA: begin
                if (st.idx_zero || st.idx_end) begin
                    cmd.fin = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    cmd.rda = 1'b1;
                    state_next = ST_RDAW;
                end
            end
            ST_RDAW: begin
                cmd.rda_eval = 1'b1;
                state_next = ST_DEN0;
            end
            ST_DEN0: begin
                cmd.den_step = 1'b1;
                state_next = ST_DEN1;
            end
            ST_DEN1: begin
                cmd.num_calc = 1'b1;
                state_next = ST_NUM;
            end
            ST_NUM: begin
                cmd.div_init = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (st.div_done) state_next = ST_FIN;
                else cmd.div_step = 1'b1;
            end
            ST_FIN: begin
                cmd.fin = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### rtl/altp_dp.sv
module altp_dp #(
    parameter int MAX_POINTS = altp_pkg::MAX_POINTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  altp_pkg::in_item_t  in_item,
    input  altp_pkg::cmd_t      cmd,
    output altp_pkg::stat_t     st,
    output altp_pkg::out_item_t out_item
);
    import altp_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    // interpolation numerator before scaling, and denominator
    localparam int PW = 32 + CW;
    localparam int NW = PW + 16;

    logic [31:0] mem [MAX_POINTS];
    logic [31:0] rd_reg;

    in_item_t item_reg;
    logic signed [31:0] prev_reg [3];
    logic [31:0] total_reg;
    logic [CW-1:0] count_reg;
    logic dropped_reg;
    logic [16:0] u_reg;

    // squared sum
    logic [1:0] k_reg;
    logic [64:0] sum_reg;
    logic ovf_reg;

    // square root
    logic [63:0] rem_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [31:0] seg;

    // query
    logic [31:0] s_reg;
    logic [CW-1:0] idx_reg;
    logic found_reg;
    logic [31:0] ci_reg, a_reg, d_reg;
    logic [NW-1:0] num_reg;
    logic [PW-1:0] den_reg;
    logic [5:0] div_cnt_reg;
    logic [NW-1:0] quo_reg;
    logic [PW:0] drem_reg;
    logic [1:0] sc_reg;
    logic [48:0] sc_acc_reg;

    // difference for current axis
    logic signed [32:0] diff;
    logic [32:0] adiff;
    logic signed [31:0] cur_p;
    always_comb begin
        case (k_reg)
            2'd0: cur_p = item_reg.point_x;
            2'd1: cur_p = item_reg.point_y;
            default: cur_p = item_reg.point_z;
        endcase
        diff = 33'(cur_p) - 33'(prev_reg[k_reg]);
        adiff = diff[32] ? 33'(-diff) : 33'(diff);
    end

    logic [63:0] sq;
    assign sq = adiff[31:0] * adiff[31:0];

    // segment length, saturated when the sum of squares overflowed
    assign seg = ovf_reg ? 32'hFFFF_FFFF : res_reg[31:0];

    logic [32:0] tot_add;
    assign tot_add = 33'(total_reg) + 33'(seg);

    logic [31:0] xq;
    assign xq = (item_reg.query_value > 32'd65536) ? 32'd65536 : item_reg.query_value;

    // partial product of the fraction with one half of the total
    logic [32:0] sc_part;
    assign sc_part = 33'(xq[16:0])
                   * 33'((sc_reg == 2'd0) ? total_reg[15:0] : total_reg[31:16]);

    logic [PW-1:0] dsub;
    logic [PW:0] dshift;
    assign dshift = {drem_reg[PW-1:0], num_reg[NW-1]};
    assign dsub = PW'(dshift - (PW+1)'(den_reg));

    logic [IW-1:0] idx_lo;
    assign idx_lo = idx_reg[IW-1:0];
    logic [IW-1:0] idx_m1;
    assign idx_m1 = IW'(idx_reg - CW'(1));

    // memory
    always_ff @(posedge aclk) begin
        if (cmd.start_curve) mem[0] <= 32'd0;
        else if (cmd.store) mem[count_reg[IW-1:0]] <= tot_add[32] ? 32'hFFFF_FFFF
                                                                 : tot_add[31:0];
        if (cmd.srch_rd) rd_reg <= mem[idx_lo];
        else if (cmd.rda) rd_reg <= mem[idx_m1];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            count_reg <= '0;
            prev_reg[0] <= '0;
            prev_reg[1] <= '0;
            prev_reg[2] <= '0;
        end else begin
            if (cmd.start_curve) begin
                total_reg <= '0;
                count_reg <= CW'(1);
                prev_reg[0] <= item_reg.point_x;
                prev_reg[1] <= item_reg.point_y;
                prev_reg[2] <= item_reg.point_z;
            end else if (cmd.store) begin
                total_reg <= tot_add[32] ? 32'hFFFF_FFFF : tot_add[31:0];
                count_reg <= count_reg + CW'(1);
                prev_reg[0] <= item_reg.point_x;
                prev_reg[1] <= item_reg.point_y;
                prev_reg[2] <= item_reg.point_z;
            end
        end
    end

    // datapath payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= in_item;
            k_reg <= '0;
            sum_reg <= '0;
            ovf_reg <= 1'b0;
            dropped_reg <= 1'b0;
            u_reg <= '0;
            sc_reg <= '0;
            sc_acc_reg <= '0;
        end
        if (cmd.drop) dropped_reg <= 1'b1;
        if (cmd.start_curve || cmd.zero_u) u_reg <= '0;
        if (cmd.sq_step) begin
            sum_reg <= sum_reg + 65'(sq);
            if (sum_reg + 65'(sq) >= 65'h1_0000_0000_0000_0000) ovf_reg <= 1'b1;
            k_reg <= k_reg + 2'd1;
        end
        if (cmd.sqrt_init) begin
            rem_reg <= sum_reg[63:0];
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end
        if (cmd.sqrt_step) begin
            bit_reg <= bit_reg >> 2;
            if ({1'b0, rem_reg} >= 65'(res_reg) + 65'(bit_reg)) begin
                rem_reg <= 64'(65'(rem_reg) - 65'(res_reg) - 65'(bit_reg));
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
        end
        // normalized scale by 16-bit chunks of total
        if (cmd.scale_step) begin
            sc_acc_reg <= sc_acc_reg + ((sc_reg == 2'd0) ? 49'(sc_part)
                                                         : (49'(sc_part) << 16));
            sc_reg <= sc_reg + 2'd1;
        end
        if (cmd.clamp) begin
            if (item_reg.operation == OP_NORM)
                s_reg <= sc_acc_reg[47:16] > total_reg ? total_reg : sc_acc_reg[47:16];
            else
                s_reg <= item_reg.query_value > total_reg ? total_reg : item_reg.query_value;
            idx_reg <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.srch_eval) begin
            if (rd_reg >= s_reg) begin
                found_reg <= 1'b1;
                ci_reg <= rd_reg;
            end else begin
                idx_reg <= idx_reg + CW'(1);
            end
        end
        if (cmd.rda_eval) begin
            a_reg <= rd_reg;
            d_reg <= (ci_reg - rd_reg == 32'd0) ? 32'd1 : ci_reg - rd_reg;
        end
        if (cmd.den_step) den_reg <= PW'(d_reg) * PW'(count_reg - CW'(1));
        if (cmd.num_calc) num_reg <= NW'((NW'(d_reg) * NW'(idx_reg - CW'(1))
                                          + NW'(s_reg - a_reg)) << 16);
        if (cmd.div_init) begin
            drem_reg <= '0;
            div_cnt_reg <= '0;
            quo_reg <= '0;
        end
        if (cmd.div_step) begin
            if (dshift >= (PW+1)'(den_reg)) begin
                drem_reg <= {1'b0, dsub};
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end else begin
                drem_reg <= dshift;
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
            num_reg <= {num_reg[NW-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + 6'd1;
        end
        if (cmd.fin) begin
            if (idx_reg == '0) u_reg <= '0;
            else if (idx_reg == count_reg) u_reg <= 17'd65536;
            else u_reg <= (quo_reg > NW'(65536)) ? 17'd65536 : quo_reg[16:0];
        end
    end

    // status
    always_comb begin
        st.op = item_reg.operation;
        st.empty = (count_reg == '0);
        st.full = (count_reg >= CW'(MAX_POINTS));
        st.sq_done = (k_reg == 2'd3);
        st.sq_ovf = ovf_reg;
        st.sqrt_done = (bit_reg == '0);
        st.srch_done = found_reg || (idx_reg == count_reg);
        st.idx_zero = (idx_reg == '0);
        st.idx_end = (idx_reg == count_reg);
        st.div_done = (div_cnt_reg == 6'(NW));
        out_item.u_value = u_reg;
        out_item.total_length = total_reg;
        out_item.point_count = 7'(count_reg);
        out_item.point_dropped = dropped_reg;
    end

endmodule

### rtl/arc_length_to_parameter_table_top.sv
// start or drop give their result directly; append runs three square steps and
// 32 square-root steps; a query gives u zero when empty or matched at entry 0,
// else interpolates at matched entry i (linear scan, 55-step divider at 64 points);
// normalized queries scale first; one item at a time, the next one taken the cycle
// after the result leaves; aresetn synchronous active low clears total, count
// and last point; the length table needs no clearing, only written entries are read
module arc_length_to_parameter_table_top #(
    parameter int MAX_POINTS = altp_pkg::MAX_POINTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  altp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output altp_pkg::out_item_t m_data
);
    import altp_pkg::*;

    cmd_t  cmd;
    stat_t st;

    // controller
    altp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .out_valid(m_valid), .out_ready(m_ready),
        .st(st), .cmd(cmd)
    );

    // datapath
    altp_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_item(s_data), .cmd(cmd), .st(st), .out_item(m_data)
    );

endmodule

### rtl/altp_checker.sv
module altp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input altp_pkg::out_item_t m_data
);
    import altp_pkg::*;

    // no new item while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");

    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");

    // u never above one
    a_u: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.u_value <= 17'd65536) else $error("u out of range");

    // accepted item never gives a result in the cycle after it is taken
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid) else $error("result too early");

endmodule

bind arc_length_to_parameter_table_top altp_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
